// ----- rtl/sjmp_pkg.sv -----
// Package for the synchronized joint move planner.
// Holds codes, state types, widths and reset values; no dependencies.
package sjmp_pkg;

    localparam int SJMP_JOINTS = 16;
    localparam int DIV_W       = 64;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 72;

    localparam logic [31:0] MAX_VELOCITY_RESET = 32'd65536;
    localparam logic [19:0] TICK_PERIOD_RESET  = 20'd2500;
    localparam logic [4:0]  JOINT_COUNT_RESET  = 5'd12;
    localparam logic [19:0] US_PER_SECOND      = 20'd1000000;

    typedef enum logic [1:0] {
        CFG_MAX_VELOCITY = 2'd0,
        CFG_TICK_PERIOD  = 2'd1,
        CFG_JOINT_COUNT  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_NEXT  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_VEL_ZERO    = 3'd1,
        STATUS_TICK_ZERO   = 3'd2,
        STATUS_NO_GOALS    = 3'd3,
        STATUS_QUEUE_EMPTY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_MOVING = 2'd1,
        PH_FREEZE = 2'd2
    } phase_t;

    localparam logic KIND_POS_VEL = 1'b0;
    localparam logic KIND_FREEZE  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_STEP_MUL1,
        ST_STEP_MUL2,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_VEL_RD,
        ST_VEL_MUL,
        ST_VEL_GO,
        ST_VEL_WAIT,
        ST_TICK_RD,
        ST_TICK_MUL,
        ST_TICK_GO,
        ST_TICK_WAIT,
        ST_FRZ,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/sjmp_store.sv -----
// Joint store: goal/error memory and velocity memory, registered read.
// Depends on sjmp_pkg.
module sjmp_store #(
    parameter int JOINTS = sjmp_pkg::SJMP_JOINTS,
    parameter int AW     = (JOINTS > 1) ? $clog2(JOINTS) : 1
) (
    input  logic               aclk,
    input  logic [AW-1:0]      rd_addr,
    output logic signed [31:0] rd_goal,
    output logic signed [32:0] rd_err,
    output logic signed [32:0] rd_vel,
    input  logic               ge_we,
    input  logic [AW-1:0]      ge_addr,
    input  logic signed [31:0] ge_goal,
    input  logic signed [32:0] ge_err,
    input  logic               v_we,
    input  logic [AW-1:0]      v_addr,
    input  logic signed [32:0] v_data
);
    import sjmp_pkg::*;

    logic [64:0] ge_mem [JOINTS];
    logic [32:0] v_mem  [JOINTS];
    logic [64:0] ge_q_reg;
    logic [32:0] v_q_reg;

    always_ff @(posedge aclk) begin
        if (ge_we) begin
            ge_mem[ge_addr] <= {ge_err, ge_goal};
        end
        ge_q_reg <= ge_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (v_we) begin
            v_mem[v_addr] <= v_data;
        end
        v_q_reg <= v_mem[rd_addr];
    end

    assign rd_goal = ge_q_reg[31:0];
    assign rd_err  = ge_q_reg[64:32];
    assign rd_vel  = v_q_reg;

endmodule

// ----- rtl/sjmp_divider.sv -----
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on sjmp_pkg for the operand width.
module sjmp_divider (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [sjmp_pkg::DIV_W-1:0] dividend,
    input  logic [sjmp_pkg::DIV_W-1:0] divisor,
    output logic             done,
    output logic [sjmp_pkg::DIV_W-1:0] quotient
);
    import sjmp_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= diff[DIV_W] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ~diff[DIV_W]};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/synchronized_joint_move_planner.sv -----
// Channel  | Dir | Handshake         | Payload
// s_       | in  | s_tvalid/s_tready | tuser: mode; tdata: joint, meas, goal, present
// m_       | out | m_tvalid/m_tready | tuser: kind; tdata: status, joint, pos, vel; tlast
// cfg_     | in  | cfg_wr_en         | cfg_index, cfg_wdata
// Every divide goes through the shared divider at one quotient bit per cycle. A start
// with no goal and a tick with a zero step count skip the divide; load, clear,
// queue-empty and freeze items use no divide at all.
// Reset clears control state and goal flags. A stalled result only pauses the
// sequencer; the next input beat is taken once the last result sits in m_.
// Top level: sequencer and multiplier; uses sjmp_pkg, sjmp_store, sjmp_divider.
module synchronized_joint_move_planner #(
    parameter int JOINTS = sjmp_pkg::SJMP_JOINTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] joint_index, [35:4] measured_position, [67:36] goal_position,
    // [68] goal_present, [71:69] zero
    input  logic [sjmp_pkg::IN_DATA_W-1:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [6:3] out_joint, [38:7] command_position,
    // [71:39] command_velocity
    output logic [sjmp_pkg::OUT_DATA_W-1:0] m_tdata,
    // [0] command_kind
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import sjmp_pkg::*;

    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int NW = $clog2(JOINTS + 1);

    state_t state_reg, state_next, ret_reg, ret_next;
    phase_t phase_reg, phase_next;

    logic [31:0] mv_reg;
    logic [19:0] tick_reg;
    logic [4:0]  jc_reg;

    logic [1:0]  mode_reg;
    logic [3:0]  idx_reg;
    logic signed [31:0] meas_reg, goalin_reg;
    logic        pres_reg;

    logic [31:0] step_total_reg, step_total_next;
    logic [31:0] step_now_reg, step_now_next;
    logic [32:0] maxerr_reg, maxerr_next;
    logic [NW-1:0] j_reg, j_next;
    logic [JOINTS-1:0] flag_reg, flag_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next, dvs_reg, dvs_next;
    logic        sign_reg, sign_next;
    logic signed [31:0] goal_reg, goal_next;

    logic [2:0]  res_status_reg, res_status_next;
    logic [3:0]  res_joint_reg, res_joint_next;
    logic        res_kind_reg, res_kind_next;
    logic [31:0] res_pos_reg, res_pos_next;
    logic [32:0] res_vel_reg, res_vel_next;
    logic        res_last_reg, res_last_next;

    logic        m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic        m_user_reg, m_last_reg;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;

    logic        div_start, div_done;
    logic [DIV_W-1:0] div_q;

    logic [AW-1:0] rd_addr;
    logic signed [31:0] rd_goal;
    logic signed [32:0] rd_err, rd_vel;
    logic [32:0] rd_mag;
    logic        ge_we, v_we;
    logic [AW-1:0] ge_addr;
    logic signed [31:0] ge_goal;
    logic signed [32:0] ge_err, v_data;

    logic [NW-1:0] n_act;
    logic        j_last;
    logic        out_load;
    logic        in_accept;
    logic [AW+3:0] idx_wide;
    logic [NW+3:0] j_wide;
    logic        idx_bad;
    logic [31:0] m_sat;
    logic [33:0] pos_sum;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    assign mul_p = mul_a * mul_b;

    always_comb begin
        if (jc_reg == 5'd0) begin
            n_act = NW'(1);
        end else if (32'(jc_reg) > JOINTS) begin
            n_act = NW'(JOINTS);
        end else begin
            n_act = NW'(jc_reg);
        end
    end

    assign j_last   = (j_reg == n_act - 1'b1);
    assign rd_addr  = j_reg[AW-1:0];
    assign rd_mag   = rd_err[32] ? (~rd_err + 33'd1) : rd_err;
    assign idx_wide = {{AW{1'b0}}, idx_reg};
    assign j_wide   = {4'b0, j_reg};
    assign idx_bad  = (32'(idx_reg) >= JOINTS);
    assign m_sat    = (div_q > {32'b0, mv_reg}) ? mv_reg : div_q[31:0];
    assign pos_sum  = sign_reg ? ({{2{goal_reg[31]}}, goal_reg} + {1'b0, div_q[32:0]})
                               : ({{2{goal_reg[31]}}, goal_reg} - {1'b0, div_q[32:0]});

    sjmp_store #(.JOINTS(JOINTS), .AW(AW)) u_store (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_goal (rd_goal),
        .rd_err  (rd_err),
        .rd_vel  (rd_vel),
        .ge_we   (ge_we),
        .ge_addr (ge_addr),
        .ge_goal (ge_goal),
        .ge_err  (ge_err),
        .v_we    (v_we),
        .v_addr  (rd_addr),
        .v_data  (v_data)
    );

    sjmp_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        phase_next      = phase_reg;
        step_total_next = step_total_reg;
        step_now_next   = step_now_reg;
        maxerr_next     = maxerr_reg;
        j_next          = j_reg;
        flag_next       = flag_reg;
        dvd_next        = dvd_reg;
        dvs_next        = dvs_reg;
        sign_next       = sign_reg;
        goal_next       = goal_reg;
        res_status_next = res_status_reg;
        res_joint_next  = res_joint_reg;
        res_kind_next   = res_kind_reg;
        res_pos_next    = res_pos_reg;
        res_vel_next    = res_vel_reg;
        res_last_next   = res_last_reg;
        mul_a           = '0;
        mul_b           = '0;
        div_start       = 1'b0;
        ge_we           = 1'b0;
        ge_addr         = idx_wide[AW-1:0];
        ge_goal         = pres_reg ? goalin_reg : meas_reg;
        ge_err          = pres_reg ? ({goalin_reg[31], goalin_reg} - {meas_reg[31], meas_reg})
                                   : 33'sd0;
        v_we            = 1'b0;
        v_data          = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                res_status_next = STATUS_OK;
                res_joint_next  = 4'd0;
                res_kind_next   = KIND_POS_VEL;
                res_pos_next    = '0;
                res_vel_next    = '0;
                res_last_next   = 1'b1;
                ret_next        = ST_IDLE;
                state_next      = ST_EMIT;
                case (mode_reg)
                    MODE_LOAD: begin
                        res_joint_next = idx_reg;
                        if (phase_reg == PH_IDLE && !idx_bad) begin
                            ge_we = 1'b1;
                            flag_next[idx_wide[AW-1:0]] = pres_reg;
                            res_pos_next = ge_goal;
                        end
                    end
                    MODE_START: begin
                        if (mv_reg == '0) begin
                            res_status_next = STATUS_VEL_ZERO;
                        end else if (tick_reg == '0) begin
                            res_status_next = STATUS_TICK_ZERO;
                        end else begin
                            phase_next      = PH_IDLE;
                            step_now_next   = '0;
                            step_total_next = '0;
                            maxerr_next     = '0;
                            j_next          = '0;
                            state_next      = ST_SCAN_RD;
                        end
                    end
                    MODE_CLEAR: begin
                        phase_next      = PH_IDLE;
                        step_now_next   = '0;
                        step_total_next = '0;
                    end
                    MODE_NEXT: begin
                        j_next = '0;
                        if (phase_reg == PH_MOVING) begin
                            state_next = ST_TICK_RD;
                        end else if (phase_reg == PH_FREEZE) begin
                            state_next = ST_FRZ;
                        end else begin
                            res_status_next = STATUS_QUEUE_EMPTY;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (flag_reg[rd_addr] && rd_mag > maxerr_reg) begin
                    maxerr_next = rd_mag;
                end
                if (j_last) begin
                    state_next = ST_STEP_MUL1;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_STEP_MUL1: begin
                if (maxerr_reg == '0) begin
                    res_status_next = STATUS_NO_GOALS;
                    state_next      = ST_EMIT;
                end else begin
                    mul_a      = maxerr_reg;
                    mul_b      = {12'b0, US_PER_SECOND};
                    dvd_next   = mul_p[DIV_W-1:0];
                    state_next = ST_STEP_MUL2;
                end
            end
            ST_STEP_MUL2: begin
                mul_a      = {1'b0, mv_reg};
                mul_b      = {12'b0, tick_reg};
                dvs_next   = mul_p[DIV_W-1:0];
                state_next = ST_STEP_GO;
            end
            ST_STEP_GO: begin
                div_start  = 1'b1;
                state_next = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
                if (div_done) begin
                    step_total_next = (div_q[63:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
                    j_next          = '0;
                    state_next      = ST_VEL_RD;
                end
            end
            ST_VEL_RD: begin
                state_next = ST_VEL_MUL;
            end
            ST_VEL_MUL: begin
                mul_a      = rd_mag;
                mul_b      = mv_reg;
                dvd_next   = mul_p[DIV_W-1:0];
                dvs_next   = {31'b0, maxerr_reg};
                sign_next  = rd_err[32];
                state_next = ST_VEL_GO;
            end
            ST_VEL_GO: begin
                div_start  = 1'b1;
                state_next = ST_VEL_WAIT;
            end
            ST_VEL_WAIT: begin
                if (div_done) begin
                    v_we   = 1'b1;
                    v_data = sign_reg ? -$signed({1'b0, m_sat}) : $signed({1'b0, m_sat});
                    if (j_last) begin
                        phase_next = PH_MOVING;
                        state_next = ST_EMIT;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_VEL_RD;
                    end
                end
            end
            ST_TICK_RD: begin
                state_next = ST_TICK_MUL;
            end
            ST_TICK_MUL: begin
                goal_next      = rd_goal;
                sign_next      = rd_err[32];
                res_status_next = STATUS_OK;
                res_joint_next = j_wide[3:0];
                res_kind_next  = KIND_POS_VEL;
                res_vel_next   = rd_vel;
                res_last_next  = j_last;
                ret_next       = ST_TICK_RD;
                if (step_total_reg == '0) begin
                    res_pos_next = rd_goal;
                    state_next   = ST_EMIT;
                    if (j_last) begin
                        phase_next = PH_FREEZE;
                    end
                end else begin
                    mul_a      = rd_mag;
                    mul_b      = step_total_reg - step_now_reg;
                    dvd_next   = mul_p[DIV_W-1:0];
                    dvs_next   = {32'b0, step_total_reg};
                    state_next = ST_TICK_GO;
                end
            end
            ST_TICK_GO: begin
                div_start  = 1'b1;
                state_next = ST_TICK_WAIT;
            end
            ST_TICK_WAIT: begin
                if (div_done) begin
                    res_pos_next = pos_sum[31:0];
                    state_next   = ST_EMIT;
                    if (j_last) begin
                        if (step_now_reg >= step_total_reg) begin
                            phase_next = PH_FREEZE;
                        end else begin
                            step_now_next = step_now_reg + 32'd1;
                        end
                    end
                end
            end
            ST_FRZ: begin
                res_status_next = STATUS_OK;
                res_joint_next  = j_wide[3:0];
                res_kind_next   = KIND_FREEZE;
                res_pos_next    = '0;
                res_vel_next    = '0;
                res_last_next   = j_last;
                ret_next        = ST_FRZ;
                state_next      = ST_EMIT;
                if (j_last) begin
                    phase_next    = PH_IDLE;
                    step_now_next = '0;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    if (res_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ret_reg;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            phase_reg      <= PH_IDLE;
            step_total_reg <= '0;
            step_now_reg   <= '0;
            flag_reg       <= '0;
            j_reg          <= '0;
            mv_reg         <= MAX_VELOCITY_RESET;
            tick_reg       <= TICK_PERIOD_RESET;
            jc_reg         <= JOINT_COUNT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            phase_reg      <= phase_next;
            step_total_reg <= step_total_next;
            step_now_reg   <= step_now_next;
            flag_reg       <= flag_next;
            j_reg          <= j_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAX_VELOCITY: mv_reg   <= cfg_wdata;
                    CFG_TICK_PERIOD:  tick_reg <= cfg_wdata[19:0];
                    CFG_JOINT_COUNT:  jc_reg   <= cfg_wdata[4:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        maxerr_reg     <= maxerr_next;
        dvd_reg        <= dvd_next;
        dvs_reg        <= dvs_next;
        sign_reg       <= sign_next;
        goal_reg       <= goal_next;
        res_status_reg <= res_status_next;
        res_joint_reg  <= res_joint_next;
        res_kind_reg   <= res_kind_next;
        res_pos_reg    <= res_pos_next;
        res_vel_reg    <= res_vel_next;
        res_last_reg   <= res_last_next;
        if (in_accept) begin
            mode_reg   <= s_tuser;
            idx_reg    <= s_tdata[3:0];
            meas_reg   <= s_tdata[35:4];
            goalin_reg <= s_tdata[67:36];
            pres_reg   <= s_tdata[68];
        end
        if (out_load) begin
            m_data_reg <= {res_vel_reg, res_pos_reg, res_joint_reg, res_status_reg};
            m_user_reg <= res_kind_reg;
            m_last_reg <= res_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // one item at a time: a taken beat closes the input until its results are out
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_step_order: assert property (@(posedge aclk) disable iff (!aresetn)
        step_now_reg <= step_total_reg)
        else $error("tick counter ran past step total");

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_STEP_WAIT || state_reg == ST_VEL_WAIT
                      || state_reg == ST_TICK_WAIT))
        else $error("divider finished outside a wait state");

    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_last_reg && res_kind_reg == KIND_FREEZE) |=> phase_reg == PH_IDLE)
        else $error("freeze round did not return planner to idle");
`endif

endmodule

// ----- tb/tb_synchronized_joint_move_planner.sv -----
// Self-checking bench for the synchronized joint move planner.
// Drives load/start/next/clear beats, predicts every command beat and checks them.
// Depends on sjmp_pkg and the planner RTL only.
module tb_synchronized_joint_move_planner;
    timeunit 1ns;
    timeprecision 1ps;
    import sjmp_pkg::*;

    localparam int NJ = 16;
    localparam longint LIMIT = 3000000;

    typedef struct {
        mode_t       mode;
        logic [3:0]  jidx;
        logic [31:0] meas;
        logic [31:0] goal;
        logic        present;
    } plan_beat_t;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  joint;
        logic        kind;
        logic [31:0] pos;
        logic [32:0] vel;
        logic        last;
    } cmd_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    synchronized_joint_move_planner u_top (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // planner shadow state
    longint unsigned vmax, tick, jcnt;
    longint goal_m[NJ], err_m[NJ], vel_m[NJ];
    bit     flag_m[NJ];
    longint unsigned steps_tot, steps_now;
    phase_t phase_m;

    plan_beat_t pending[$];
    cmd_beat_t  expected_cmds[$];
    int         err_count = 0;
    longint     cycles = 0;

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic void push_cmd(logic [2:0] st, int j, logic kind, longint pos,
                                     longint vel, bit last);
        cmd_beat_t c;
        c.status = st; c.joint = j[3:0]; c.kind = kind;
        c.pos = pos[31:0]; c.vel = vel[32:0]; c.last = last;
        expected_cmds = {expected_cmds, c};
    endfunction

    function automatic logic [2:0] plan_move();
        int n = jcnt < 1 ? 1 : (jcnt > NJ ? NJ : int'(jcnt));
        longint unsigned maxerr = 0, q, m;
        if (vmax == 0) return STATUS_VEL_ZERO;
        if (tick == 0) return STATUS_TICK_ZERO;
        phase_m = PH_IDLE; steps_now = 0; steps_tot = 0;
        for (int j = 0; j < n; j++)
            if (flag_m[j] && mag(err_m[j]) > maxerr) maxerr = mag(err_m[j]);
        if (maxerr == 0) return STATUS_NO_GOALS;
        q = (maxerr * 64'd1000000) / (vmax * tick);
        steps_tot = q > 64'hFFFFFFFF ? 64'hFFFFFFFF : q;
        for (int j = 0; j < n; j++) begin
            m = mag(err_m[j]) * vmax / maxerr;
            if (m > vmax) m = vmax;
            vel_m[j] = err_m[j] < 0 ? -longint'(m) : longint'(m);
        end
        phase_m = PH_MOVING;
        return STATUS_OK;
    endfunction

    function automatic void predict_cmds(plan_beat_t b);
        int n = jcnt < 1 ? 1 : (jcnt > NJ ? NJ : int'(jcnt));
        longint pos, g;
        longint unsigned m;
        case (b.mode)
            MODE_LOAD: begin
                if (phase_m != PH_IDLE) begin
                    push_cmd(STATUS_OK, b.jidx, KIND_POS_VEL, 0, 0, 1);
                end else begin
                    g = b.present ? longint'($signed(b.goal)) : longint'($signed(b.meas));
                    goal_m[b.jidx] = g;
                    err_m[b.jidx] = g - longint'($signed(b.meas));
                    flag_m[b.jidx] = b.present;
                    push_cmd(STATUS_OK, b.jidx, KIND_POS_VEL, g, 0, 1);
                end
            end
            MODE_START: push_cmd(plan_move(), 0, KIND_POS_VEL, 0, 0, 1);
            MODE_CLEAR: begin
                phase_m = PH_IDLE; steps_now = 0; steps_tot = 0;
                push_cmd(STATUS_OK, 0, KIND_POS_VEL, 0, 0, 1);
            end
            default: begin
                if (phase_m == PH_MOVING) begin
                    for (int j = 0; j < n; j++) begin
                        pos = goal_m[j];
                        if (steps_tot != 0) begin
                            m = mag(err_m[j]) * (steps_tot - steps_now) / steps_tot;
                            pos = err_m[j] < 0 ? pos + longint'(m) : pos - longint'(m);
                        end
                        push_cmd(STATUS_OK, j, KIND_POS_VEL, pos, vel_m[j], j + 1 == n);
                    end
                    if (steps_now >= steps_tot) phase_m = PH_FREEZE;
                    else steps_now++;
                end else if (phase_m == PH_FREEZE) begin
                    for (int j = 0; j < n; j++)
                        push_cmd(STATUS_OK, j, KIND_FREEZE, 0, 0, j + 1 == n);
                    phase_m = PH_IDLE; steps_now = 0;
                end else begin
                    push_cmd(STATUS_QUEUE_EMPTY, 0, KIND_POS_VEL, 0, 0, 1);
                end
            end
        endcase
    endfunction

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_err(string what, logic [63:0] got, logic [63:0] exp_v);
        err_count++;
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp_v);
    endtask

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_cmds(pending[0]);
                pending.delete(0);
                s_gap = gap_len();
            end
            if ((!s_tvalid || s_tready) ) begin
                if (s_gap > 0 || pending.size() == 0) begin
                    if (s_gap > 0) s_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending[0].mode;
                    s_tdata  <= {3'b0, pending[0].present, pending[0].goal,
                                 pending[0].meas, pending[0].jidx};
                end
            end
        end
    end

    // monitor
    int m_gap = 0;
    always @(posedge aclk) begin
        cmd_beat_t e;
        cycles++;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    report_err("command beat with nothing expected", 0, 0);
                end else begin
                    e = expected_cmds[0];
                    expected_cmds.delete(0);
                    if (m_tdata[2:0] !== e.status) report_err("status", m_tdata[2:0], e.status);
                    if (m_tdata[6:3] !== e.joint) report_err("joint", m_tdata[6:3], e.joint);
                    if (m_tuser !== e.kind) report_err("kind", m_tuser, e.kind);
                    if (m_tdata[38:7] !== e.pos) report_err("position", m_tdata[38:7], e.pos);
                    if (m_tdata[71:39] !== e.vel) report_err("velocity", m_tdata[71:39], e.vel);
                    if (m_tlast !== e.last) report_err("tlast", m_tlast, e.last);
                end
                m_gap = gap_len();
            end
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MAX_VELOCITY: vmax = val;
            CFG_TICK_PERIOD:  tick = val[19:0];
            default:          jcnt = val[4:0];
        endcase
    endtask

    task automatic queue_beat(mode_t md, int j, logic [31:0] me, logic [31:0] go, logic pr);
        plan_beat_t b;
        b.mode = md; b.jidx = j[3:0]; b.meas = me; b.goal = go; b.present = pr;
        pending = {pending, b};
    endtask

    task automatic drain();
        wait (pending.size() == 0 && expected_cmds.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    // goal near the base: an error of at most span either way
    function automatic logic [31:0] near(logic [31:0] base, int span);
        return base + $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic load_all(int n, int span);
        logic [31:0] me;
        for (int j = 0; j < n; j++) begin
            me = $urandom();
            queue_beat(MODE_LOAD, j, me, near(me, span), $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic run_move(int ticks);
        queue_beat(MODE_START, $urandom_range(0, 15), $urandom(), $urandom(),
                   $urandom_range(0, 1));
        for (int t = 0; t < ticks; t++)
            queue_beat(MODE_NEXT, $urandom_range(0, 15), $urandom(), $urandom(),
                       $urandom_range(0, 1));
    endtask

    initial begin
        int n, r;
        vmax = 65536; tick = 2500; jcnt = 12;
        phase_m = PH_IDLE; steps_tot = 0; steps_now = 0;
        for (int j = 0; j < NJ; j++) begin
            goal_m[j] = 0; err_m[j] = 0; vel_m[j] = 0; flag_m[j] = 0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, empty queue, clear, bad settings, short move
        queue_beat(MODE_NEXT, 0, 0, 0, 0);
        queue_beat(MODE_START, 0, 0, 0, 0);
        queue_beat(MODE_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        queue_beat(MODE_LOAD, 15, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        queue_beat(MODE_LOAD, 1, 32'hFFFF_FFFF, 32'h0000_0000, 0);
        queue_beat(MODE_CLEAR, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        drain();
        write_reg(CFG_JOINT_COUNT, 2);
        write_reg(CFG_MAX_VELOCITY, 32'hFFFF_FFFF);
        write_reg(CFG_TICK_PERIOD, 1);
        queue_beat(MODE_LOAD, 1, 32'h10, 32'h10, 1);
        run_move(3);
        queue_beat(MODE_LOAD, 3, 1, 2, 1);
        queue_beat(MODE_NEXT, 0, 0, 0, 0);
        drain();
        write_reg(CFG_MAX_VELOCITY, 0);
        queue_beat(MODE_START, 0, 0, 0, 0);
        drain();
        write_reg(CFG_MAX_VELOCITY, 1);
        write_reg(CFG_TICK_PERIOD, 0);
        queue_beat(MODE_START, 0, 0, 0, 0);
        drain();
        write_reg(CFG_TICK_PERIOD, 1000000);
        queue_beat(MODE_LOAD, 0, 5, 0, 0);
        queue_beat(MODE_LOAD, 1, 5, 0, 0);
        queue_beat(MODE_START, 0, 0, 0, 0);
        drain();
        // tiny limit with huge error: step count saturates
        write_reg(CFG_MAX_VELOCITY, 1);
        write_reg(CFG_TICK_PERIOD, 1);
        queue_beat(MODE_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1);
        run_move(2);
        queue_beat(MODE_CLEAR, 0, 0, 0, 0);
        drain();

        // random phases: random settings, each move followed by 1 to 6 next beats
        for (int ph = 0; ph < 6; ph++) begin
            n = ph == 0 ? 16 : (ph == 1 ? 1 : $urandom_range(1, 16));
            write_reg(CFG_JOINT_COUNT, ph == 2 ? 0 : (ph == 3 ? 31 : n));
            n = jcnt < 1 ? 1 : (jcnt > 16 ? 16 : int'(jcnt));
            write_reg(CFG_TICK_PERIOD, ph == 4 ? 20'd1000000 : $urandom_range(1000, 100000));
            write_reg(CFG_MAX_VELOCITY, $urandom_range(1 << 12, 1 << 24));
            load_all(n, $urandom_range(0, 3) == 0 ? 64 : 1 << 16);
            r = $urandom_range(0, 3);
            if (r == 0) queue_beat(MODE_CLEAR, 0, $urandom(), $urandom(), 1);
            run_move($urandom_range(1, 6));
            if ($urandom_range(0, 1))
                queue_beat(MODE_LOAD, $urandom_range(0, 15), $urandom(), $urandom(), 1);
            queue_beat(MODE_NEXT, 0, $urandom(), $urandom(), 0);
            if ($urandom_range(0, 2) == 0) queue_beat(MODE_CLEAR, 0, 0, 0, 0);
            drain();
        end
        drain();
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/sjmp_pkg.sv
rtl/sjmp_store.sv
rtl/sjmp_divider.sv
rtl/synchronized_joint_move_planner.sv
tb/tb_synchronized_joint_move_planner.sv
